[design/pid_pkg.sv]
package pid_pkg;

  // operation codes of an input transaction
  localparam logic OP_COMPUTE = 1'b0;
  localparam logic OP_LOAD    = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INT_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT  = 3'd5;

  localparam logic [30:0] PERIOD_RESET = 31'd65536;

  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] setpoint;
    logic signed [31:0] measured;
    logic signed [31:0] integral_load;
  } in_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic signed [31:0] integral_value;
  } out_t;

  // saturate a 34 bit sum to the q16.16 range
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (!v[33] && (v[32:31] != 2'b00)) begin
      r = Q_MAX;
    end else if (v[33] && (v[32:31] != 2'b11)) begin
      r = Q_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // q16.16 product: floor of product >> 16, saturated
  function automatic logic signed [31:0] qsat(input logic signed [63:0] p);
    logic signed [31:0] r;
    if ((&p[63:47]) || !(|p[63:47])) begin
      r = p[47:16];
    end else if (p[63]) begin
      r = Q_MIN;
    end else begin
      r = Q_MAX;
    end
    return r;
  endfunction

  // symmetric clamp, zero limit disables
  function automatic logic signed [31:0] clampsym(input logic signed [31:0] v,
                                                  input logic [30:0] lim);
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    logic signed [31:0] r;
    hi = $signed({1'b0, lim});
    lo = -hi;
    if (lim == '0) begin
      r = v;
    end else if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[design/pid_div.sv]
module pid_div import pid_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] dividend,
  input  logic        [30:0] divisor,
  output logic               done,
  output logic signed [31:0] quotient
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [63:0] num_r;
  logic [30:0] rem_r;
  logic [30:0] dsr_r;
  logic        neg_r;
  logic        zero_r;

  logic [31:0] t1;
  logic [31:0] t2;
  logic        ge1;
  logic        ge2;
  logic [30:0] r1;
  logic [30:0] r2;
  logic [63:0] mag;

  // two restoring steps per cycle
  always_comb begin
    t1  = {rem_r, num_r[63]};
    ge1 = (t1 >= {1'b0, dsr_r});
    r1  = ge1 ? 31'(t1 - {1'b0, dsr_r}) : t1[30:0];
    t2  = {r1, num_r[62]};
    ge2 = (t2 >= {1'b0, dsr_r});
    r2  = ge2 ? 31'(t2 - {1'b0, dsr_r}) : t2[30:0];
  end

  assign mag = dividend[63] ? 64'(-dividend) : 64'(dividend);

  // sequencing of the division
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      num_r  <= mag;
      rem_r  <= '0;
      dsr_r  <= divisor;
      neg_r  <= dividend[63];
      zero_r <= (divisor == '0);
    end else if (busy_r) begin
      num_r <= {num_r[61:0], ge1, ge2};
      rem_r <= r2;
    end
  end

  // sign and saturation of the quotient magnitude; a zero divisor gives zero
  always_comb begin
    if (zero_r) begin
      quotient = '0;
    end else if (neg_r) begin
      if ((|num_r[63:32]) || (num_r[31] && (|num_r[30:0]))) begin
        quotient = Q_MIN;
      end else begin
        quotient = -$signed(num_r[31:0]);
      end
    end else if (|num_r[63:31]) begin
      quotient = Q_MAX;
    end else begin
      quotient = $signed(num_r[31:0]);
    end
  end

  assign done = done_r;

endmodule

[design/pid_controller_clamped.sv]
// channel  direction  handshake             payload
// in       input      in_valid / in_stall   in_data (in_t)
// out      output     out_valid / out_stall out_data (out_t)
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// a compute transaction makes four passes through the shared 32x32 multiplier
// and the 64 bit derivative division (two quotient bits per cycle), which starts
// after the second pass and overlaps the last two; a load transaction skips the
// multiplier and the division.
// in_stall is high from acceptance until the result is in the output register.
// the output register holds a result while out_stall is high.
// synchronous active low reset clears the control, configuration and controller state and loads the default period.
module pid_controller_clamped import pid_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_M1   = 3'd1;
  localparam logic [2:0] S_M2   = 3'd2;
  localparam logic [2:0] S_M3   = 3'd3;
  localparam logic [2:0] S_M4   = 3'd4;
  localparam logic [2:0] S_M5   = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // configuration
  logic        [30:0] period_r;
  logic signed [31:0] kp_r;
  logic signed [31:0] ki_r;
  logic signed [31:0] kd_r;
  logic        [30:0] ilim_r;
  logic        [30:0] olim_r;

  // controller state
  logic signed [31:0] integral_r;
  logic signed [31:0] prev_err_r;
  logic signed [31:0] last_drive_r;

  // working registers
  logic signed [31:0] err_r;
  logic signed [31:0] delta_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] p_r;
  logic signed [33:0] acc_r;
  logic               out_valid_r;
  out_t               out_data_r;

  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] mul_p;
  logic               accept;
  logic               out_free;
  logic               div_done;
  logic signed [31:0] div_q;
  logic signed [31:0] integral_nxt;
  logic signed [31:0] drive_nxt;

  assign accept    = in_valid && (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_data.operation == OP_LOAD) ? S_DONE : S_M1;
        end
      end
      S_M1:   state_nxt = S_M2;
      S_M2:   state_nxt = S_M3;
      S_M3:   state_nxt = S_M4;
      S_M4:   state_nxt = S_M5;
      S_M5:   state_nxt = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      S_M1: begin
        mul_a = err_r;
        mul_b = $signed({1'b0, period_r});
      end
      S_M2: begin
        mul_a = kd_r;
        mul_b = delta_r;
      end
      S_M3: begin
        mul_a = kp_r;
        mul_b = err_r;
      end
      S_M4: begin
        mul_a = ki_r;
        mul_b = integral_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // integral update and final drive
  assign integral_nxt = clampsym(sat34(34'(integral_r) + 34'(qsat(prod_r))), ilim_r);
  assign drive_nxt    = clampsym(sat34(acc_r + 34'(div_q)), olim_r);

  pid_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_M3),
    .dividend (prod_r),
    .divisor  (period_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // control, configuration and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      period_r     <= PERIOD_RESET;
      kp_r         <= '0;
      ki_r         <= '0;
      kd_r         <= '0;
      ilim_r       <= '0;
      olim_r       <= '0;
      integral_r   <= '0;
      prev_err_r   <= '0;
      last_drive_r <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PERIOD:     period_r <= cfg_data[30:0];
          REG_PROP_GAIN:  kp_r     <= $signed(cfg_data);
          REG_INT_GAIN:   ki_r     <= $signed(cfg_data);
          REG_DERIV_GAIN: kd_r     <= $signed(cfg_data);
          REG_INT_LIMIT:  ilim_r   <= cfg_data[30:0];
          REG_OUT_LIMIT:  olim_r   <= cfg_data[30:0];
          default: ;
        endcase
      end

      if (accept && (in_data.operation == OP_LOAD)) begin
        integral_r <= in_data.integral_load;
      end
      if (state_r == S_M2) begin
        integral_r <= integral_nxt;
      end
      if ((state_r == S_DIV) && div_done) begin
        last_drive_r <= drive_nxt;
        prev_err_r   <= err_r;
      end

      // output register handshake
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (accept) begin
      err_r <= sat34(34'(in_data.setpoint) - 34'(in_data.measured));
    end
    if (state_r == S_M1) begin
      delta_r <= sat34(34'(err_r) - 34'(prev_err_r));
    end
    if (state_r == S_M4) begin
      p_r <= qsat(prod_r);
    end
    if (state_r == S_M5) begin
      acc_r <= 34'(p_r) + 34'(qsat(prod_r));
    end
    if ((state_r == S_DONE) && out_free) begin
      out_data_r.drive          <= last_drive_r;
      out_data_r.integral_value <= integral_r;
    end
  end

endmodule
